/* sv/rmst_pkg.sv */
// rmst_pkg: shared types and constants for the range maximum segment tree unit
// no dependencies; compiled before every other file of the block

package rmst_pkg;

   localparam int POS_W          = 10;
   localparam int DATA_W         = 32;
   localparam int DEFAULT_LEAVES = 1024;

   typedef enum logic [0:0] {
      REQ_SET   = 1'b0,
      REQ_QUERY = 1'b1
   } rmst_req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_MERGE,
      ST_QRY_WALK,
      ST_QRY_DRAIN,
      ST_QRY_DONE
   } rmst_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_write;
      logic upd_start;
      logic leaf_write;
      logic merge;
      logic qry_start;
      logic walk;
      logic rsp_load;
   } rmst_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic req_query;
      logic req_in_range;
      logic at_root;
      logic lo_le_hi;
      logic rsp_free;
   } rmst_status_type;

endpackage

/* sv/rmst_if.sv */
// rmst_req_if / rmst_rsp_if: valid-ready channels of the segment tree unit
// depends on rmst_pkg

interface rmst_req_if;
   import rmst_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [POS_W-1:0]  first_position;
   logic [POS_W-1:0]  last_position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output req_type, output first_position,
                   output last_position, output value, input ready);
   modport sink   (input valid, input req_type, input first_position,
                   input last_position, input value, output ready);
endinterface

interface rmst_rsp_if;
   import rmst_pkg::*;

   logic              valid;
   logic              ready;
   logic signed [DATA_W-1:0] range_maximum;

   modport source (output valid, output range_maximum, input ready);
   modport sink   (input valid, input range_maximum, output ready);
endinterface

/* sv/rmst_ctrl.sv */
// rmst_ctrl: sequencer of the segment tree unit (clear pass, update walk, query walk)
// depends on rmst_pkg; drives rmst_dpath through rmst_cmd_type

module rmst_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rmst_pkg::rmst_status_type status,
   output rmst_pkg::rmst_cmd_type    cmd
);
   import rmst_pkg::*;

   rmst_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.req_query) begin
                  cmd.qry_start = 1'b1;
                  state_in      = ST_QRY_WALK;
               end else if (status.req_in_range) begin
                  cmd.upd_start = 1'b1;
                  state_in      = ST_UPD_LEAF;
               end
            end
         end
         ST_UPD_LEAF: begin
            cmd.leaf_write = 1'b1;
            state_in       = ST_UPD_MERGE;
         end
         ST_UPD_MERGE: begin
            cmd.merge = 1'b1;
            if (status.at_root) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY_WALK: begin
            cmd.walk = 1'b1;
            if (!status.lo_le_hi) begin
               state_in = ST_QRY_DRAIN;
            end
         end
         ST_QRY_DRAIN: begin
            state_in = ST_QRY_DONE;
         end
         ST_QRY_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/rmst_dpath.sv */
// rmst_dpath: node memory, update and query walkers, result register
// depends on rmst_pkg; commanded by rmst_ctrl

module rmst_dpath #(
   parameter int LEAVES = rmst_pkg::DEFAULT_LEAVES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rmst_pkg::rmst_cmd_type             cmd,
   output rmst_pkg::rmst_status_type          status,
   input  logic                              req_type,
   input  logic [rmst_pkg::POS_W-1:0]         first_position,
   input  logic [rmst_pkg::POS_W-1:0]         last_position,
   input  logic signed [rmst_pkg::DATA_W-1:0] value,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic signed [rmst_pkg::DATA_W-1:0] range_maximum
);
   import rmst_pkg::*;

   localparam int NODES = 2 * LEAVES;
   localparam int NW    = $clog2(NODES);
   localparam int CW    = NW + 1;

   logic signed [DATA_W-1:0] mem [NODES];

   logic [NW-1:0]            clr_ff;
   logic [NW-1:0]            node_ff;
   logic signed [DATA_W-1:0] acc_ff;
   logic [CW-1:0]            lo_ff, hi_ff;
   logic                     first_ff;
   logic                     pend_valid_ff, pend_init_ff, pend_a_ff, pend_b_ff;
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [DATA_W-1:0] best_ff, best_in, best_base;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;

   logic [31:0]              first_sat, last_sat;
   logic [CW-1:0]            lo_in, hi_in, lo_step, hi_step;
   logic                     lo_le_hi, take_b;
   logic [NW-1:0]            parent;
   logic signed [DATA_W-1:0] merged;
   logic                     we;
   logic [NW-1:0]            wa, ra, rb;
   logic signed [DATA_W-1:0] wd;

   // query bounds saturate to the last leaf
   assign first_sat = (32'(first_position) >= 32'(LEAVES)) ? 32'(LEAVES - 1)
                                                            : 32'(first_position);
   assign last_sat  = (32'(last_position) >= 32'(LEAVES)) ? 32'(LEAVES - 1)
                                                           : 32'(last_position);

   assign lo_le_hi = (lo_ff <= hi_ff);
   assign lo_step  = lo_ff + CW'(lo_ff[0]);
   assign take_b   = (lo_step <= hi_ff) && !hi_ff[0];
   assign hi_step  = hi_ff - CW'(take_b);
   assign lo_in    = lo_step >> 1;
   assign hi_in    = hi_step >> 1;

   assign parent = node_ff >> 1;
   assign merged = (rd_a_ff > acc_ff) ? rd_a_ff : acc_ff;

   always_comb begin
      we = 1'b0;
      wa = '0;
      wd = '0;
      if (cmd.clear_write) begin
         we = 1'b1;
         wa = clr_ff;
      end else if (cmd.leaf_write) begin
         we = 1'b1;
         wa = node_ff;
         wd = acc_ff;
      end else if (cmd.merge) begin
         we = 1'b1;
         wa = parent;
         wd = merged;
      end
   end

   // port a: sibling during updates, low bound during queries
   always_comb begin
      if (cmd.walk) begin
         ra = lo_ff[NW-1:0];
      end else if (cmd.merge) begin
         ra = parent ^ NW'(1);
      end else begin
         ra = node_ff ^ NW'(1);
      end
   end
   assign rb = hi_ff[NW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_a_ff <= mem[ra];
      rd_b_ff <= mem[rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_ff <= clr_ff + NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_start) begin
         node_ff <= NW'(32'(first_position) + 32'(LEAVES));
         acc_ff  <= value;
      end else if (cmd.merge) begin
         node_ff <= parent;
         acc_ff  <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.qry_start) begin
         lo_ff    <= CW'(first_sat + 32'(LEAVES));
         hi_ff    <= CW'(last_sat + 32'(LEAVES));
         first_ff <= 1'b1;
      end else if (cmd.walk) begin
         first_ff <= 1'b0;
         if (lo_le_hi) begin
            lo_ff <= lo_in;
            hi_ff <= hi_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= cmd.walk && (lo_le_hi || first_ff);
      end
      pend_init_ff <= first_ff;
      pend_a_ff    <= lo_le_hi && lo_ff[0];
      pend_b_ff    <= lo_le_hi && take_b;
   end

   // the first read seeds the maximum with the low leaf
   always_comb begin
      if (pend_init_ff) begin
         best_base = rd_a_ff;
      end else if (pend_a_ff && (rd_a_ff > best_ff)) begin
         best_base = rd_a_ff;
      end else begin
         best_base = best_ff;
      end
      best_in = (pend_b_ff && (rd_b_ff > best_base)) ? rd_b_ff : best_base;
   end

   always_ff @(posedge clock) begin
      if (pend_valid_ff) begin
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= best_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign range_maximum = rsp_data_ff;

   always_comb begin
      status              = '0;
      status.clear_last   = (clr_ff == NW'(NODES - 1));
      status.req_query    = (req_type == REQ_QUERY);
      status.req_in_range = (32'(first_position) < 32'(LEAVES));
      status.at_root      = (parent == NW'(1));
      status.lo_le_hi     = lo_le_hi;
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   a_merge_not_node0: assert property (@(posedge clock) disable iff (reset)
      cmd.merge |-> parent != '0)
      else $error("merge targets unused node zero");

   a_leaf_in_leaf_half: assert property (@(posedge clock) disable iff (reset)
      cmd.leaf_write |-> 32'(node_ff) >= 32'(LEAVES))
      else $error("leaf write below the leaf half");

   a_walk_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk && lo_le_hi) |-> 32'(hi_ff) < 32'(NODES))
      else $error("query walk reads beyond the node store");

   a_pend_from_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> $past(cmd.walk))
      else $error("accumulate without a walk read");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_valid_ff && rsp_data_ff == $past(best_ff)))
      else $error("result register not loaded with the maximum");

endmodule

/* sv/range_max_segment_tree_unit.sv */
// update: leaf write then one merge per level, up to the root
// query: a walk of one level per cycle, then a drain state, then the result register is
//   loaded once the result channel is free
// throughput: one item at a time; the next transfer is taken once the unit is back in idle,
//   after a query also held by any stall on the result channel
// reset: a clearing pass zeroes all 2*LEAVES nodes of the node memory, req_ready low
// depends on rmst_pkg, rmst_if, rmst_ctrl, rmst_dpath

module range_max_segment_tree_unit #(
   parameter int LEAVES = rmst_pkg::DEFAULT_LEAVES
) (
   input logic         clock,
   input logic         reset,
   rmst_req_if.sink    req_chan,
   rmst_rsp_if.source  rsp_chan
);
   import rmst_pkg::*;

   rmst_cmd_type    cmd;
   rmst_status_type status;

   // sequencer: owns the request handshake and the walk lengths
   rmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // node memory with one write and two read ports; result register drives rsp
   rmst_dpath #(
      .LEAVES (LEAVES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_chan.req_type),
      .first_position (req_chan.first_position),
      .last_position  (req_chan.last_position),
      .value          (req_chan.value),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .range_maximum  (rsp_chan.range_maximum)
   );

endmodule
